/* rtl/assert_macros.svh */
// assertion macros used by the rtl
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// property holds at every edge out of reset
`define ASSERT_ALWAYS(lbl, clk, rst, prop) \
  lbl: assert property (@(posedge clk) disable iff (rst) (prop)) \
    else $error("assertion failed");

// antecedent implies consequent in the same cycle
`define ASSERT_IMPLIES(lbl, clk, rst, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("assertion failed");

`endif

/* rtl/bca_pkg.sv */
`timescale 1ns / 1ps
`default_nettype none
package bca_pkg;

  localparam int MAX_BLOCKS = 4;
  localparam int MAX_CHUNKS = 256;
  localparam int ROWS_PER_BLK = MAX_CHUNKS / 8;
  localparam int ROWS = MAX_BLOCKS * ROWS_PER_BLK;
  localparam int BLK_W = $clog2(MAX_BLOCKS);
  localparam int BYTE_W = $clog2(ROWS_PER_BLK);
  localparam int ROW_W = BLK_W + BYTE_W;
  localparam int ACT_W = $clog2(MAX_BLOCKS + 1);
  localparam int CNT_W = $clog2(MAX_CHUNKS + 1);
  localparam int SLOTI_W = $clog2(MAX_CHUNKS);
  localparam int SL_W = 14;
  localparam int STRIDE_W = SL_W + CNT_W;
  localparam int DIV_K_W = $clog2(SLOTI_W);

  localparam logic [7:0] BYTE_FULL = 8'hff;

  localparam logic [7:0] REG_CHUNK_SIZE = 8'd0;
  localparam logic [7:0] REG_CHUNK_COUNT = 8'd1;
  localparam logic [7:0] REG_REGION_BASE = 8'd2;
  localparam logic [7:0] REG_HEADER_BYTES = 8'd3;

  typedef enum logic [1:0] {
    ST_OK = 2'd0,
    ST_FULL = 2'd1,
    ST_BAD = 2'd2
  } status_t;

  typedef enum logic {
    CMD_ALLOC = 1'b0,
    CMD_FREE = 1'b1
  } cmd_t;

  typedef enum logic [3:0] {
    S_IDLE,
    S_A_RD,
    S_A_CHK,
    S_A_NEW,
    S_F_PREP,
    S_F_BLK,
    S_F_DIV,
    S_F_RD,
    S_F_WR,
    S_MUL,
    S_MUL2,
    S_SUM,
    S_OUT
  } state_t;

  typedef struct packed {
    logic [12:0] payload_size;
    logic [8:0] chunk_count;
    logic [31:0] region_base;
    logic [3:0] header_bytes;
  } cfg_t;

  typedef struct packed {
    cmd_t op;
    logic [31:0] addr;
  } q_item_t;

endpackage
`default_nettype wire

/* rtl/bca_front.sv */
`timescale 1ns / 1ps
`default_nettype none
module bca_front (
  input wire logic clk,
  input wire logic rst,
  input wire logic in_valid,
  output logic in_stall,
  input wire logic cmd,
  input wire logic [31:0] chunk_address,
  output logic q_valid,
  output bca_pkg::q_item_t q_item,
  input wire logic q_pop
);
  import bca_pkg::*;

  q_item_t slots [2];
  logic wptr;
  logic rptr;
  logic [1:0] fill;
  logic push;
  q_item_t item_in;

  always_comb begin
    item_in.op = (cmd == 1'b1) ? CMD_FREE : CMD_ALLOC;
    item_in.addr = (cmd == 1'b1) ? chunk_address : 32'd0;
  end

  assign in_stall = (fill == 2'd2);
  assign push = in_valid && !in_stall;
  assign q_valid = (fill != 2'd0);
  assign q_item = slots[rptr];

  always_ff @(posedge clk) begin
    if (push) begin
      slots[wptr] <= item_in;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wptr <= 1'b0;
      rptr <= 1'b0;
      fill <= 2'd0;
    end else begin
      if (push) begin
        wptr <= ~wptr;
      end
      if (q_pop && q_valid) begin
        rptr <= ~rptr;
      end
      fill <= fill + {1'b0, push} - {1'b0, q_pop && q_valid};
    end
  end

endmodule
`default_nettype wire

/* rtl/bca_back.sv */
`timescale 1ns / 1ps
`default_nettype none
`include "assert_macros.svh"
module bca_back (
  input wire logic clk,
  input wire logic rst,
  input wire bca_pkg::cfg_t cfg,
  input wire logic q_valid,
  input wire bca_pkg::q_item_t q_item,
  output logic q_pop,
  output logic out_valid,
  input wire logic out_stall,
  output logic [1:0] status,
  output logic [31:0] result_address,
  output logic [1:0] block_index,
  output logic [7:0] slot_index
);
  import bca_pkg::*;

  state_t state;
  state_t state_next;

  logic [7:0] mem [ROWS];
  logic [ROWS-1:0] row_vld;
  logic [7:0] rd_data;
  logic rd_vld;
  logic mem_re;
  logic mem_we;
  logic [ROW_W-1:0] mem_row;
  logic [7:0] mem_wdata;

  logic [ACT_W-1:0] act;
  logic [BLK_W-1:0] blk_r;
  logic [BYTE_W-1:0] byte_r;
  logic [SLOTI_W-1:0] slot_r;
  logic [ACT_W-1:0] fblk;
  logic [31:0] addr_r;
  logic [31:0] off;
  logic [STRIDE_W-1:0] stride_r;
  logic [STRIDE_W-1:0] rem;
  logic [DIV_K_W-1:0] div_k;
  logic [STRIDE_W-1:0] prod_i;
  logic [31:0] prod_b;
  status_t st_r;
  logic [31:0] res_r;

  logic [12:0] cs_eff;
  logic [SL_W-1:0] sl;
  logic [8:0] c8;
  logic [9:0] c_rnd;
  logic [CNT_W-1:0] cnt;
  logic [CNT_W-4:0] nbytes;
  logic [7:0] cur;
  logic [2:0] low;
  logic last_byte;
  logic [STRIDE_W-1:0] dvs;
  logic load_out;

  always_comb begin
    cs_eff = (cfg.payload_size == 13'd0) ? 13'd1 : cfg.payload_size;
    sl = {1'b0, cs_eff} + {10'd0, cfg.header_bytes};
    c8 = (cfg.chunk_count < 9'd8) ? 9'd8 : cfg.chunk_count;
    c_rnd = ({1'b0, c8} + 10'd7) & ~10'd7;
    cnt = (c_rnd > 10'(MAX_CHUNKS)) ? CNT_W'(MAX_CHUNKS) : c_rnd[CNT_W-1:0];
    nbytes = cnt[CNT_W-1:3];
    cur = rd_vld ? rd_data : BYTE_FULL;
    low = 3'd0;
    for (int i = 7; i >= 0; i--) begin
      if (cur[i]) begin
        low = 3'(i);
      end
    end
    last_byte = (({1'b0, byte_r} + 1'b1) >= nbytes);
    dvs = STRIDE_W'(sl) << div_k;
    load_out = !out_valid || !out_stall;
  end

  always_comb begin
    state_next = state;
    unique case (state)
      S_IDLE: begin
        if (q_valid) begin
          state_next = (q_item.op == CMD_FREE) ? S_F_PREP : S_A_RD;
        end
      end
      S_A_RD: state_next = S_A_CHK;
      S_A_CHK: begin
        priority if (cur != 8'd0) begin
          state_next = S_MUL;
        end else if (!last_byte || blk_r != '0) begin
          state_next = S_A_RD;
        end else if (act < ACT_W'(MAX_BLOCKS)) begin
          state_next = S_A_NEW;
        end else begin
          state_next = S_OUT;
        end
      end
      S_A_NEW: state_next = S_MUL;
      S_F_PREP: state_next = S_F_BLK;
      S_F_BLK: begin
        if (fblk == act || off < 32'(stride_r)) begin
          state_next = (fblk == act) ? S_OUT : S_F_DIV;
        end
      end
      S_F_DIV: begin
        if (div_k == '0) begin
          state_next = S_F_RD;
        end
      end
      S_F_RD: state_next = (rem == '0) ? S_F_WR : S_OUT;
      S_F_WR: state_next = S_OUT;
      S_MUL: state_next = S_MUL2;
      S_MUL2: state_next = S_SUM;
      S_SUM: state_next = S_OUT;
      S_OUT: begin
        if (load_out) begin
          state_next = S_IDLE;
        end
      end
      default: state_next = S_IDLE;
    endcase
  end

  always_comb begin
    q_pop = 1'b0;
    mem_re = 1'b0;
    mem_we = 1'b0;
    mem_row = {blk_r, byte_r};
    mem_wdata = cur;
    unique case (state)
      S_IDLE: q_pop = q_valid;
      S_A_RD: mem_re = 1'b1;
      S_A_CHK: begin
        mem_we = (cur != 8'd0);
        mem_wdata = cur & ~(8'd1 << low);
      end
      S_A_NEW: begin
        mem_we = 1'b1;
        mem_row = {act[BLK_W-1:0], BYTE_W'(0)};
        mem_wdata = BYTE_FULL & ~8'd1;
      end
      S_F_RD: begin
        mem_re = (rem == '0);
        mem_row = {blk_r, slot_r[SLOTI_W-1:3]};
      end
      S_F_WR: begin
        mem_we = 1'b1;
        mem_row = {blk_r, slot_r[SLOTI_W-1:3]};
        mem_wdata = cur | (8'd1 << slot_r[2:0]);
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem[mem_row] <= mem_wdata;
    end
    if (mem_re) begin
      rd_data <= mem[mem_row];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      row_vld <= '0;
      rd_vld <= 1'b0;
      act <= ACT_W'(1);
    end else begin
      if (mem_re) begin
        rd_vld <= row_vld[mem_row];
      end
      if (state == S_A_NEW) begin
        for (int i = 0; i < ROWS_PER_BLK; i++) begin
          row_vld[{act[BLK_W-1:0], BYTE_W'(i)}] <= 1'b0;
        end
        act <= act + 1'b1;
      end
      if (mem_we) begin
        row_vld[mem_row] <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    unique case (state)
      S_IDLE: begin
        addr_r <= q_item.addr;
        blk_r <= BLK_W'(act - 1'b1);
        byte_r <= '0;
        slot_r <= '0;
        st_r <= ST_OK;
        res_r <= 32'd0;
      end
      S_A_CHK: begin
        priority if (cur != 8'd0) begin
          slot_r <= {byte_r, low};
        end else if (!last_byte) begin
          byte_r <= byte_r + 1'b1;
        end else if (blk_r != '0) begin
          blk_r <= blk_r - 1'b1;
          byte_r <= '0;
        end else begin
          st_r <= ST_FULL;
          blk_r <= '0;
          slot_r <= '0;
        end
      end
      S_A_NEW: begin
        st_r <= ST_OK;
        blk_r <= act[BLK_W-1:0];
        slot_r <= '0;
      end
      S_F_PREP: begin
        stride_r <= STRIDE_W'(sl) * STRIDE_W'(cnt);
        off <= addr_r - cfg.region_base - {28'd0, cfg.header_bytes};
        fblk <= '0;
      end
      S_F_BLK: begin
        priority if (fblk == act) begin
          st_r <= ST_BAD;
          blk_r <= '0;
        end else if (off < 32'(stride_r)) begin
          blk_r <= fblk[BLK_W-1:0];
          rem <= off[STRIDE_W-1:0];
          div_k <= DIV_K_W'(SLOTI_W - 1);
        end else begin
          off <= off - 32'(stride_r);
          fblk <= fblk + 1'b1;
        end
      end
      S_F_DIV: begin
        if (rem >= dvs) begin
          rem <= rem - dvs;
          slot_r[div_k] <= 1'b1;
        end
        div_k <= div_k - 1'b1;
      end
      S_F_RD: begin
        if (rem != '0) begin
          st_r <= ST_BAD;
          blk_r <= '0;
          slot_r <= '0;
        end
      end
      S_MUL: begin
        stride_r <= STRIDE_W'(sl) * STRIDE_W'(cnt);
        prod_i <= STRIDE_W'(slot_r) * STRIDE_W'(sl);
      end
      S_MUL2: prod_b <= 32'(blk_r) * 32'(stride_r);
      S_SUM: begin
        res_r <= cfg.region_base + prod_b + 32'(prod_i) + {28'd0, cfg.header_bytes};
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      out_valid <= 1'b0;
    end else begin
      state <= state_next;
      if (state == S_OUT && load_out) begin
        out_valid <= 1'b1;
      end else if (!out_stall) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (state == S_OUT && load_out) begin
      status <= st_r;
      result_address <= res_r;
      block_index <= 2'(blk_r);
      slot_index <= 8'(slot_r);
    end
  end

  `ASSERT_ALWAYS(a_act_range, clk, rst, act >= ACT_W'(1) && act <= ACT_W'(MAX_BLOCKS))
  `ASSERT_IMPLIES(a_we_state, clk, rst, mem_we,
    state == S_A_CHK || state == S_A_NEW || state == S_F_WR)
  `ASSERT_IMPLIES(a_full_zero, clk, rst, out_valid && status != ST_OK,
    result_address == 32'd0 && block_index == 2'd0 && slot_index == 8'd0)

endmodule
`default_nettype wire

/* rtl/bitmap_chunk_allocator.sv */
`timescale 1ns / 1ps
`default_nettype none
// Fixed-size chunk allocator over four blocks of up to 256 chunks each, with a free
// bitmap kept in a 128-byte memory. Requests enter a two-entry queue and are carried
// out one at a time. An allocate reads the bitmap one byte at a time, newest block
// first, checking each byte after it is read, and opens a new block when every active
// block is full and fewer than four are in use. A free steps past whole blocks by
// subtracting the block stride, then finds the slot by an eight-step division.
// Configuration is written through cfg_valid/cfg_ready (always ready) and must only
// change while the block is idle.
module bitmap_chunk_allocator (
  input wire logic clk,
  input wire logic rst,
  input wire logic cfg_valid,
  output logic cfg_ready,
  input wire logic [7:0] cfg_index,
  input wire logic [31:0] cfg_data,
  input wire logic in_valid,
  output logic in_stall,
  input wire logic cmd,
  input wire logic [31:0] chunk_address,
  output logic out_valid,
  input wire logic out_stall,
  output logic [1:0] status,
  output logic [31:0] result_address,
  output logic [1:0] block_index,
  output logic [7:0] slot_index
);
  import bca_pkg::*;

  cfg_t cfg;
  logic q_valid;
  q_item_t q_item;
  logic q_pop;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.payload_size <= 13'd64;
      cfg.chunk_count <= 9'd64;
      cfg.region_base <= 32'd0;
      cfg.header_bytes <= 4'd4;
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_index)
        REG_CHUNK_SIZE: cfg.payload_size <= cfg_data[12:0];
        REG_CHUNK_COUNT: cfg.chunk_count <= cfg_data[8:0];
        REG_REGION_BASE: cfg.region_base <= cfg_data;
        REG_HEADER_BYTES: cfg.header_bytes <= cfg_data[3:0];
        default: begin
        end
      endcase
    end
  end

  bca_front u_front (
    .clk(clk),
    .rst(rst),
    .in_valid(in_valid),
    .in_stall(in_stall),
    .cmd(cmd),
    .chunk_address(chunk_address),
    .q_valid(q_valid),
    .q_item(q_item),
    .q_pop(q_pop)
  );

  bca_back u_back (
    .clk(clk),
    .rst(rst),
    .cfg(cfg),
    .q_valid(q_valid),
    .q_item(q_item),
    .q_pop(q_pop),
    .out_valid(out_valid),
    .out_stall(out_stall),
    .status(status),
    .result_address(result_address),
    .block_index(block_index),
    .slot_index(slot_index)
  );

endmodule
`default_nettype wire
